// ===== design/zcrof_pkg.sv =====
package zcrof_pkg;

   localparam int MAX_POINTS    = 4096;
   localparam int COORD_BITS    = 24;
   localparam int ADDR_BITS     = $clog2(MAX_POINTS);
   localparam int CNT_BITS      = 13;
   localparam int RADIUS_BITS   = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * RADIUS_BITS;
   localparam int SUM_BITS      = SQ_BITS + 2;
   localparam int WORD_BITS     = 3 * COORD_BITS;

   localparam logic signed [COORD_BITS-1:0] CLIP_Z_MIN_RST    = COORD_BITS'(-410);
   localparam logic signed [COORD_BITS-1:0] CLIP_Z_MAX_RST    = COORD_BITS'(410);
   localparam logic [RADIUS_BITS-1:0]       SEARCH_RADIUS_RST = RADIUS_BITS'(154);
   localparam logic [CNT_BITS-1:0]          MIN_NEIGHBORS_RST = CNT_BITS'(80);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CLIP_Z_MIN    = 2'd0,
      CSR_CLIP_Z_MAX    = 2'd1,
      CSR_SEARCH_RADIUS = 2'd2,
      CSR_MIN_NEIGHBORS = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_SWEEP,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_load;
      logic rd_target;
      logic latch_target;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic query_valid;
      logic sweep_last;
      logic pipe_busy;
   } status_type;

endpackage

// ===== design/zcrof_ctrl.sv =====
module zcrof_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_type,
   input  zcrof_pkg::status_type  status,
   output logic                   busy,
   output logic                   rsp_strobe,
   output zcrof_pkg::cmd_type     cmd
);

   zcrof_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zcrof_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         zcrof_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_type == zcrof_pkg::REQ_QUERY) ? zcrof_pkg::ST_FETCH
                                                              : zcrof_pkg::ST_LOAD;
            end
         end
         zcrof_pkg::ST_LOAD:  state_in = zcrof_pkg::ST_IDLE;
         zcrof_pkg::ST_FETCH: begin
            state_in = status.query_valid ? zcrof_pkg::ST_LATCH : zcrof_pkg::ST_RESP;
         end
         zcrof_pkg::ST_LATCH: state_in = zcrof_pkg::ST_SWEEP;
         zcrof_pkg::ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = zcrof_pkg::ST_DRAIN;
            end
         end
         zcrof_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = zcrof_pkg::ST_RESP;
            end
         end
         zcrof_pkg::ST_RESP:  state_in = zcrof_pkg::ST_IDLE;
         default:             state_in = zcrof_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         zcrof_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         zcrof_pkg::ST_LOAD:  cmd.do_load      = 1'b1;
         zcrof_pkg::ST_FETCH: cmd.rd_target    = 1'b1;
         zcrof_pkg::ST_LATCH: cmd.latch_target = 1'b1;
         zcrof_pkg::ST_SWEEP: cmd.issue        = 1'b1;
         zcrof_pkg::ST_DRAIN: ;
         zcrof_pkg::ST_RESP:  rsp_strobe       = 1'b1;
         default:             busy             = 1'b1;
      endcase
   end

endmodule

// ===== design/zcrof_dp.sv =====
module zcrof_dp (
   input  logic                                         clock,
   input  logic                                         reset,
   input  zcrof_pkg::cmd_type                           cmd,
   output zcrof_pkg::status_type                        status,
   input  logic                                         req_first,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_x,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_y,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_z,
   input  logic [zcrof_pkg::ADDR_BITS-1:0]              req_query_index,
   input  logic                                         csr_we,
   input  logic [zcrof_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  logic [zcrof_pkg::CSR_DATA_BITS-1:0]          csr_wdata,
   output logic                                         rsp_valid_res,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_x,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_y,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_z,
   output logic [zcrof_pkg::CNT_BITS-1:0]               rsp_neighbor_count,
   output logic                                         rsp_keep,
   output logic [zcrof_pkg::CNT_BITS-1:0]               rsp_stored_total,
   output logic                                         rsp_overflowed
);

   localparam int COORD_BITS  = zcrof_pkg::COORD_BITS;
   localparam int ADDR_BITS   = zcrof_pkg::ADDR_BITS;
   localparam int CNT_BITS    = zcrof_pkg::CNT_BITS;
   localparam int RADIUS_BITS = zcrof_pkg::RADIUS_BITS;
   localparam int DIFF_BITS   = zcrof_pkg::DIFF_BITS;
   localparam int SQ_BITS     = zcrof_pkg::SQ_BITS;
   localparam int SUM_BITS    = zcrof_pkg::SUM_BITS;
   localparam int WORD_BITS   = zcrof_pkg::WORD_BITS;

   function automatic logic [DIFF_BITS-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
      logic signed [DIFF_BITS-1:0] d;
      d = DIFF_BITS'(a) - DIFF_BITS'(b);
      return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
   endfunction

   // configuration registers
   logic signed [COORD_BITS-1:0] clip_min_ff, clip_min_in;
   logic signed [COORD_BITS-1:0] clip_max_ff, clip_max_in;
   logic [RADIUS_BITS-1:0]       radius_ff, radius_in;
   logic [CNT_BITS-1:0]          min_nb_ff, min_nb_in;
   logic [SQ_BITS-1:0]           rsq_ff, rsq_in;

   always_comb begin
      clip_min_in = clip_min_ff;
      clip_max_in = clip_max_ff;
      radius_in   = radius_ff;
      min_nb_in   = min_nb_ff;
      if (csr_we) begin
         case (zcrof_pkg::csr_index_type'(csr_index))
            zcrof_pkg::CSR_CLIP_Z_MIN:    clip_min_in = csr_wdata[COORD_BITS-1:0];
            zcrof_pkg::CSR_CLIP_Z_MAX:    clip_max_in = csr_wdata[COORD_BITS-1:0];
            zcrof_pkg::CSR_SEARCH_RADIUS: radius_in   = csr_wdata[RADIUS_BITS-1:0];
            zcrof_pkg::CSR_MIN_NEIGHBORS: min_nb_in   = csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsq_in = radius_ff * radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_min_ff <= zcrof_pkg::CLIP_Z_MIN_RST;
         clip_max_ff <= zcrof_pkg::CLIP_Z_MAX_RST;
         radius_ff   <= zcrof_pkg::SEARCH_RADIUS_RST;
         min_nb_ff   <= zcrof_pkg::MIN_NEIGHBORS_RST;
      end else begin
         clip_min_ff <= clip_min_in;
         clip_max_ff <= clip_max_in;
         radius_ff   <= radius_in;
         min_nb_ff   <= min_nb_in;
      end
   end

   always_ff @(posedge clock) begin
      rsq_ff <= rsq_in;
   end

   // captured transaction
   logic                         first_ff, first_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [ADDR_BITS-1:0]         idx_ff, idx_in;

   always_comb begin
      first_in = cmd.capture ? req_first       : first_ff;
      px_in    = cmd.capture ? req_point_x     : px_ff;
      py_in    = cmd.capture ? req_point_y     : py_ff;
      pz_in    = cmd.capture ? req_point_z     : pz_ff;
      idx_in   = cmd.capture ? req_query_index : idx_ff;
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      idx_ff   <= idx_in;
   end

   // load path
   logic [CNT_BITS-1:0] total_ff, total_in, base;
   logic                ovf_ff, ovf_in;
   logic                in_range, room, wr_en;

   always_comb begin
      base     = first_ff ? '0 : total_ff;
      in_range = (pz_ff >= clip_min_ff) && (pz_ff <= clip_max_ff);
      room     = base < CNT_BITS'(zcrof_pkg::MAX_POINTS);
      wr_en    = cmd.do_load && in_range && room;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (cmd.do_load) begin
         total_in = (in_range && room) ? base + CNT_BITS'(1) : base;
         ovf_in   = (!first_ff && ovf_ff) || (in_range && !room);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   // point memory, one read port with registered data
   logic [WORD_BITS-1:0] point_mem [zcrof_pkg::MAX_POINTS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ADDR_BITS-1:0] j_ff, j_in;

   assign rd_addr = cmd.rd_target ? idx_ff : j_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[base[ADDR_BITS-1:0]] <= {px_ff, py_ff, pz_ff};
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   always_comb begin
      j_in = j_ff;
      if (cmd.rd_target) begin
         j_in = '0;
      end else if (cmd.issue) begin
         j_in = j_ff + ADDR_BITS'(1);
      end
   end

   // queried point
   logic [WORD_BITS-1:0] tgt_ff, tgt_in;
   logic                 res_valid_ff, res_valid_in;
   logic                 query_valid;

   assign query_valid  = CNT_BITS'(idx_ff) < total_ff;
   assign tgt_in       = cmd.latch_target ? rd_data_ff : tgt_ff;
   assign res_valid_in = cmd.rd_target ? query_valid : res_valid_ff;

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      tgt_ff <= tgt_in;
   end

   // distance pipeline: abs diff, square, sum, compare and count
   logic                   rd_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                   s1_far_ff, s1_far_in, s2_far_ff, s3_far_ff;
   logic [RADIUS_BITS-1:0] d_ff [3];
   logic [RADIUS_BITS-1:0] d_in [3];
   logic [SQ_BITS-1:0]     sq_ff [3];
   logic [SQ_BITS-1:0]     sq_in [3];
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [DIFF_BITS-1:0]   diff [3];

   always_comb begin
      s1_far_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         diff[k]  = abs_diff(tgt_ff[k*COORD_BITS +: COORD_BITS],
                             rd_data_ff[k*COORD_BITS +: COORD_BITS]);
         // beyond the radius on one axis rules the point out, so 16 bits suffice
         d_in[k]  = diff[k][RADIUS_BITS-1:0];
         sq_in[k] = d_ff[k] * d_ff[k];
         if (diff[k] > DIFF_BITS'(radius_ff)) begin
            s1_far_in = 1'b1;
         end
      end
      sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
      count_in = count_ff;
      if (cmd.rd_target) begin
         count_in = '0;
      end else if (s3_vld_ff && !s3_far_ff && (sum_ff <= SUM_BITS'(rsq_ff))) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         d_ff[k]  <= d_in[k];
         sq_ff[k] <= sq_in[k];
      end
      s1_far_ff <= s1_far_in;
      s2_far_ff <= s1_far_ff;
      s3_far_ff <= s2_far_ff;
      sum_ff    <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= cmd.issue;
         s1_vld_ff    <= rd_vld_ff;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_comb begin
      status.query_valid = query_valid;
      status.sweep_last  = (CNT_BITS'(j_ff) + CNT_BITS'(1)) == total_ff;
      status.pipe_busy   = rd_vld_ff || s1_vld_ff || s2_vld_ff || s3_vld_ff;
   end

   // results
   always_comb begin
      rsp_valid_res      = res_valid_ff;
      rsp_out_x          = res_valid_ff ? tgt_ff[2*COORD_BITS +: COORD_BITS] : '0;
      rsp_out_y          = res_valid_ff ? tgt_ff[COORD_BITS +: COORD_BITS] : '0;
      rsp_out_z          = res_valid_ff ? tgt_ff[0 +: COORD_BITS] : '0;
      rsp_neighbor_count = count_ff;
      rsp_keep           = res_valid_ff && (count_ff > min_nb_ff);
      rsp_stored_total   = total_ff;
      rsp_overflowed     = ovf_ff;
   end

endmodule

// ===== design/z_clip_radius_outlier_filter.sv =====
// channel    handshake                ports
// request    start high, busy low     req_type req_first req_point_x/y/z req_query_index
// response   rsp_strobe, one cycle    rsp_valid_res rsp_out_x/y/z rsp_neighbor_count
//                                      rsp_keep rsp_stored_total rsp_overflowed
// csr        csr_we, no wait          csr_index csr_wdata
//
// a load keeps busy high for one cycle after acceptance and gives no response
// a query makes one memory read per stored point, each going through
// a four stage distance pipeline; a bad index answers without a sweep
// synchronous reset clears the point count and overflow flag and restores the csr defaults
// responses cannot be stalled; start is ignored while busy
module z_clip_radius_outlier_filter (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic                                         req_type,
   input  logic                                         req_first,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_x,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_y,
   input  logic signed [zcrof_pkg::COORD_BITS-1:0]      req_point_z,
   input  logic [zcrof_pkg::ADDR_BITS-1:0]              req_query_index,
   output logic                                         rsp_strobe,
   output logic                                         rsp_valid_res,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_x,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_y,
   output logic signed [zcrof_pkg::COORD_BITS-1:0]      rsp_out_z,
   output logic [zcrof_pkg::CNT_BITS-1:0]               rsp_neighbor_count,
   output logic                                         rsp_keep,
   output logic [zcrof_pkg::CNT_BITS-1:0]               rsp_stored_total,
   output logic                                         rsp_overflowed,
   input  logic                                         csr_we,
   input  logic [zcrof_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  logic [zcrof_pkg::CSR_DATA_BITS-1:0]          csr_wdata
);

   zcrof_pkg::cmd_type    cmd;
   zcrof_pkg::status_type status;

   zcrof_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   zcrof_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first          (req_first),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .req_query_index    (req_query_index),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_z          (rsp_out_z),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_keep           (rsp_keep),
      .rsp_stored_total   (rsp_stored_total),
      .rsp_overflowed     (rsp_overflowed)
   );

endmodule
